// ----- design/zibs_pkg.sv -----
// ----------------------------------------------------------------------------
// zibs_pkg: shared types and constants of the Z80 indexed bit/shift unit
// Opcode groups, shift operations, flag bit positions and the result record.
// ----------------------------------------------------------------------------
package zibs_pkg;

   localparam int unsigned OP_W    = 8;
   localparam int unsigned ADDR_W  = 16;
   localparam int unsigned DATA_W  = 8;
   localparam int unsigned REG_W   = 3;
   localparam int unsigned FLAGS_W = 8;

   typedef enum logic [1:0] {
      GROUP_SHIFT = 2'd0,
      GROUP_BIT   = 2'd1,
      GROUP_RES   = 2'd2,
      GROUP_SET   = 2'd3
   } group_type;

   typedef enum logic [2:0] {
      SHIFT_RLC = 3'd0,
      SHIFT_RRC = 3'd1,
      SHIFT_RL  = 3'd2,
      SHIFT_RR  = 3'd3,
      SHIFT_SLA = 3'd4,
      SHIFT_SRA = 3'd5,
      SHIFT_SLL = 3'd6,
      SHIFT_SRL = 3'd7
   } shift_type;

   // register code that names the memory operand itself
   localparam logic [REG_W-1:0] REG_MEM = 3'd6;

   localparam int unsigned FLAG_S_BIT = 7;
   localparam int unsigned FLAG_Z_BIT = 6;
   localparam int unsigned FLAG_Y_BIT = 5;
   localparam int unsigned FLAG_H_BIT = 4;
   localparam int unsigned FLAG_X_BIT = 3;
   localparam int unsigned FLAG_P_BIT = 2;
   localparam int unsigned FLAG_N_BIT = 1;
   localparam int unsigned FLAG_C_BIT = 0;

   typedef struct packed {
      logic [ADDR_W-1:0]  target_addr;
      logic               mem_write;
      logic [DATA_W-1:0]  result_byte;
      logic               reg_write;
      logic [REG_W-1:0]   reg_select;
      logic [FLAGS_W-1:0] flags_out;
   } result_type;

endpackage

// ----- design/zibs_if.sv -----
// ----------------------------------------------------------------------------
// zibs_if: request and response channels of the indexed bit/shift unit
// Valid/ready channels carrying one instruction item and one result item.
// ----------------------------------------------------------------------------
interface zibs_req_if;
   logic                                valid;
   logic                                ready;
   logic [zibs_pkg::OP_W-1:0]           op;
   logic [zibs_pkg::ADDR_W-1:0]         base_addr;
   logic signed [zibs_pkg::DATA_W-1:0]  displacement;
   logic [zibs_pkg::DATA_W-1:0]         mem_value;

   modport source (output valid, op, base_addr, displacement, mem_value, input ready);
   modport sink   (input valid, op, base_addr, displacement, mem_value, output ready);
endinterface

interface zibs_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [zibs_pkg::ADDR_W-1:0]         target_addr;
   logic                                mem_write;
   logic [zibs_pkg::DATA_W-1:0]         result_byte;
   logic                                reg_write;
   logic [zibs_pkg::REG_W-1:0]          reg_select;
   logic [zibs_pkg::FLAGS_W-1:0]        flags_out;

   modport source (output valid, target_addr, mem_write, result_byte, reg_write,
                   reg_select, flags_out, input ready);
   modport sink   (input valid, target_addr, mem_write, result_byte, reg_write,
                   reg_select, flags_out, output ready);
endinterface

// ----- design/zibs_alu.sv -----
// ----------------------------------------------------------------------------
// zibs_alu: execute datapath of the indexed bit/shift unit
// Address add, shift/rotate, BIT/RES/SET and flag update for one item.
// ----------------------------------------------------------------------------
module zibs_alu (
   input  logic [zibs_pkg::OP_W-1:0]          op,
   input  logic [zibs_pkg::ADDR_W-1:0]        base_addr,
   input  logic signed [zibs_pkg::DATA_W-1:0] displacement,
   input  logic [zibs_pkg::DATA_W-1:0]        mem_value,
   input  logic [zibs_pkg::FLAGS_W-1:0]       flags_in,
   output zibs_pkg::result_type               result
);

   zibs_pkg::group_type          group;
   zibs_pkg::shift_type          shift_op;
   logic [2:0]                   sel;
   logic [zibs_pkg::REG_W-1:0]   rcode;
   logic [zibs_pkg::DATA_W-1:0]  m;
   logic [zibs_pkg::DATA_W-1:0]  res;
   logic [zibs_pkg::DATA_W-1:0]  bit_mask;
   logic [zibs_pkg::FLAGS_W-1:0] flags;
   logic                         cin;
   logic                         cout;
   logic                         rw;

   assign group    = zibs_pkg::group_type'(op[7:6]);
   assign sel      = op[5:3];
   assign shift_op = zibs_pkg::shift_type'(sel);
   assign rcode    = op[2:0];
   assign m        = mem_value;
   assign cin      = flags_in[zibs_pkg::FLAG_C_BIT];
   assign bit_mask = zibs_pkg::DATA_W'(1) << sel;

   always_comb begin
      unique case (shift_op)
         zibs_pkg::SHIFT_RLC: begin cout = m[7]; end
         zibs_pkg::SHIFT_RRC: begin cout = m[0]; end
         zibs_pkg::SHIFT_RL:  begin cout = m[7]; end
         zibs_pkg::SHIFT_RR:  begin cout = m[0]; end
         zibs_pkg::SHIFT_SLA: begin cout = m[7]; end
         zibs_pkg::SHIFT_SRA: begin cout = m[0]; end
         zibs_pkg::SHIFT_SLL: begin cout = m[7]; end
         default:             begin cout = m[0]; end
      endcase

      res   = m;
      flags = flags_in;
      rw    = 1'b0;

      unique case (group)
         zibs_pkg::GROUP_SHIFT: begin
            unique case (shift_op)
               zibs_pkg::SHIFT_RLC: res = {m[6:0], m[7]};
               zibs_pkg::SHIFT_RRC: res = {m[0], m[7:1]};
               zibs_pkg::SHIFT_RL:  res = {m[6:0], cin};
               zibs_pkg::SHIFT_RR:  res = {cin, m[7:1]};
               zibs_pkg::SHIFT_SLA: res = {m[6:0], 1'b0};
               zibs_pkg::SHIFT_SRA: res = {m[7], m[7:1]};
               zibs_pkg::SHIFT_SLL: res = {m[6:0], 1'b1};
               default:             res = {1'b0, m[7:1]};
            endcase
            flags = '0;
            flags[zibs_pkg::FLAG_S_BIT] = res[7];
            flags[zibs_pkg::FLAG_Z_BIT] = (res == '0);
            flags[zibs_pkg::FLAG_Y_BIT] = flags_in[zibs_pkg::FLAG_Y_BIT];
            flags[zibs_pkg::FLAG_X_BIT] = flags_in[zibs_pkg::FLAG_X_BIT];
            flags[zibs_pkg::FLAG_P_BIT] = ~^res;
            flags[zibs_pkg::FLAG_C_BIT] = cout;
            rw = (rcode != zibs_pkg::REG_MEM);
         end
         zibs_pkg::GROUP_BIT: begin
            flags[zibs_pkg::FLAG_Z_BIT] = ~m[sel];
            flags[zibs_pkg::FLAG_H_BIT] = 1'b1;
            flags[zibs_pkg::FLAG_N_BIT] = 1'b0;
         end
         zibs_pkg::GROUP_RES: begin
            res = m & ~bit_mask;
            rw  = (rcode != zibs_pkg::REG_MEM);
         end
         default: begin
            res = m | bit_mask;
            rw  = (rcode != zibs_pkg::REG_MEM);
         end
      endcase

      result.target_addr = base_addr
                         + {{(zibs_pkg::ADDR_W-zibs_pkg::DATA_W){displacement[7]}},
                            displacement};
      result.mem_write   = (group != zibs_pkg::GROUP_BIT);
      result.result_byte = res;
      result.reg_write   = rw;
      result.reg_select  = rw ? rcode : '0;
      result.flags_out   = flags;
   end

endmodule

// ----- design/z80_indexed_bit_shift_unit.sv -----
// ----------------------------------------------------------------------------
// z80_indexed_bit_shift_unit: Z80 DDCB/FDCB indexed bit instruction unit
// Executes RLC/RRC/RL/RR/SLA/SRA/SLL/SRL, BIT, RES and SET on an (IX/IY+d)
// operand and keeps the flag register.
//
// Usage:
//  - req_port carries one instruction item: final opcode byte, index base,
//    signed displacement and the byte read at base plus displacement.
//  - rsp_port returns one result item per request: target address, write-back
//    byte and strobe, optional register copy and the new flag byte.
//  - The item is captured in an input register, then the datapath result and
//    new flags land in the output register.
//  - Throughput is one item per cycle unless rsp_port stalls; flags feed the
//    next item directly, so the datapath between the two registers sets it.
//  - When rsp_port is stalled, the output register holds and the input
//    register still takes one more item; req_port.ready drops only when both
//    are full.
//  - Reset clears the flag register and both valid bits.
// ----------------------------------------------------------------------------
module z80_indexed_bit_shift_unit (
   input  logic         clock,
   input  logic         reset,
   zibs_req_if.sink     req_port,
   zibs_rsp_if.source   rsp_port
);

   logic                                in_valid_ff;
   logic [zibs_pkg::OP_W-1:0]           op_ff;
   logic [zibs_pkg::ADDR_W-1:0]         base_addr_ff;
   logic signed [zibs_pkg::DATA_W-1:0]  displacement_ff;
   logic [zibs_pkg::DATA_W-1:0]         mem_value_ff;
   logic [zibs_pkg::FLAGS_W-1:0]        flags_ff;
   logic                                out_valid_ff;
   zibs_pkg::result_type                result_ff;
   zibs_pkg::result_type                result_in;
   logic                                out_load;
   logic                                advance;
   logic                                req_take;

   zibs_alu alu (
      .op           (op_ff),
      .base_addr    (base_addr_ff),
      .displacement (displacement_ff),
      .mem_value    (mem_value_ff),
      .flags_in     (flags_ff),
      .result       (result_in)
   );

   assign out_load       = !out_valid_ff || rsp_port.ready;
   assign advance        = in_valid_ff && out_load;
   assign req_port.ready = !in_valid_ff || advance;
   assign req_take       = req_port.valid && req_port.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         flags_ff     <= '0;
      end else begin
         if (req_port.ready) begin
            in_valid_ff <= req_port.valid;
         end
         if (out_load) begin
            out_valid_ff <= in_valid_ff;
         end
         if (advance) begin
            flags_ff <= result_in.flags_out;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         op_ff           <= req_port.op;
         base_addr_ff    <= req_port.base_addr;
         displacement_ff <= req_port.displacement;
         mem_value_ff    <= req_port.mem_value;
      end
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_port.valid       = out_valid_ff;
   assign rsp_port.target_addr = result_ff.target_addr;
   assign rsp_port.mem_write   = result_ff.mem_write;
   assign rsp_port.result_byte = result_ff.result_byte;
   assign rsp_port.reg_write   = result_ff.reg_write;
   assign rsp_port.reg_select  = result_ff.reg_select;
   assign rsp_port.flags_out   = result_ff.flags_out;

endmodule

// ----- design/zibs_checker.sv -----
// ----------------------------------------------------------------------------
// zibs_checker: port-level checks of the indexed bit/shift unit
// Watches the result channel over time; bound to the top level.
// ----------------------------------------------------------------------------
module zibs_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [zibs_pkg::ADDR_W-1:0]   rsp_target_addr,
   input logic                          rsp_mem_write,
   input logic [zibs_pkg::DATA_W-1:0]   rsp_result_byte,
   input logic                          rsp_reg_write,
   input logic [zibs_pkg::REG_W-1:0]    rsp_reg_select,
   input logic [zibs_pkg::FLAGS_W-1:0]  rsp_flags_out
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_target_addr)
         && $stable(rsp_result_byte) && $stable(rsp_flags_out)
         && $stable(rsp_reg_select))
      else $error("stalled result item changed");

   a_reg_copy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_reg_write |-> rsp_mem_write
         && (rsp_reg_select != zibs_pkg::REG_MEM))
      else $error("register copy without write-back or to memory code");

   a_no_copy_sel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_reg_write |-> rsp_reg_select == '0)
      else $error("register select not cleared without copy");

   a_bit_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_mem_write |-> rsp_flags_out[zibs_pkg::FLAG_H_BIT]
         && !rsp_flags_out[zibs_pkg::FLAG_N_BIT] && !rsp_reg_write)
      else $error("BIT item with wrong H/N flags or register copy");

endmodule

bind z80_indexed_bit_shift_unit zibs_checker chk (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_port.valid),
   .rsp_ready       (rsp_port.ready),
   .rsp_target_addr (rsp_port.target_addr),
   .rsp_mem_write   (rsp_port.mem_write),
   .rsp_result_byte (rsp_port.result_byte),
   .rsp_reg_write   (rsp_port.reg_write),
   .rsp_reg_select  (rsp_port.reg_select),
   .rsp_flags_out   (rsp_port.flags_out)
);

// ----- sim/tb_z80_indexed_bit_shift_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_z80_indexed_bit_shift_unit: self-checking bench for the indexed bit unit
// A directed table of DDCB/FDCB instructions, then random ones, is driven in
// bursts while the response side stalls on its own pattern, including one long
// hold-off. Every response is checked field by field against a local
// prediction of address, write-back byte, register copy and flag register.
// ----------------------------------------------------------------------------
module tb_z80_indexed_bit_shift_unit;

   localparam int unsigned RANDOM_ITEMS = 428;
   localparam int unsigned CYCLE_LIMIT  = 200000;
   localparam int unsigned HOLD_CYCLES  = 48;

   localparam logic [zibs_pkg::REG_W-1:0] REG_B = 3'd0;
   localparam logic [zibs_pkg::REG_W-1:0] REG_C = 3'd1;
   localparam logic [zibs_pkg::REG_W-1:0] REG_D = 3'd2;
   localparam logic [zibs_pkg::REG_W-1:0] REG_E = 3'd3;
   localparam logic [zibs_pkg::REG_W-1:0] REG_H = 3'd4;
   localparam logic [zibs_pkg::REG_W-1:0] REG_L = 3'd5;
   localparam logic [zibs_pkg::REG_W-1:0] REG_A = 3'd7;

   typedef enum {RX_ALWAYS, RX_COIN, RX_ONE_IN_THREE, RX_RARE_STALL} rx_pattern_type;

   typedef struct packed {
      logic [zibs_pkg::OP_W-1:0]   op;
      logic [zibs_pkg::ADDR_W-1:0] base_addr;
      logic [zibs_pkg::DATA_W-1:0] displacement;
      logic [zibs_pkg::DATA_W-1:0] mem_value;
      logic                        typed;
      zibs_pkg::result_type        want;
   } instr_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   zibs_req_if req_bus ();
   zibs_rsp_if rsp_bus ();

   z80_indexed_bit_shift_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus)
   );

   instr_row_type                directed_rows [$];
   zibs_pkg::result_type         pending_results [$];
   logic [zibs_pkg::FLAGS_W-1:0] flag_model = '0;
   int unsigned      error_count = 0;
   int unsigned      items_accepted = 0;
   int unsigned      results_checked = 0;
   int unsigned      shift_items = 0;
   int unsigned      bit_items = 0;
   int unsigned      modify_items = 0;
   int unsigned      input_stalls = 0;
   int unsigned      stall_run = 0;
   int unsigned      longest_stall = 0;
   int unsigned      burst_left = 0;
   int unsigned      cycle_count = 0;
   bit               held_off = 1'b0;

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic logic [zibs_pkg::OP_W-1:0] make_op(
         input zibs_pkg::group_type grp, input logic [2:0] sel,
         input logic [zibs_pkg::REG_W-1:0] rcode);
      return {grp, sel, rcode};
   endfunction

   function automatic zibs_pkg::result_type execute_indexed(
         input logic [zibs_pkg::OP_W-1:0] op,
         input logic [zibs_pkg::ADDR_W-1:0] base,
         input logic [zibs_pkg::DATA_W-1:0] disp,
         input logic [zibs_pkg::DATA_W-1:0] mem,
         input logic [zibs_pkg::FLAGS_W-1:0] flags);
      zibs_pkg::result_type         r;
      logic [2:0]                   sel;
      logic [zibs_pkg::REG_W-1:0]   rcode;
      logic [zibs_pkg::DATA_W-1:0]  res;
      logic [zibs_pkg::FLAGS_W-1:0] f;
      logic                         cin;
      logic                         cout;
      sel   = op[5:3];
      rcode = op[zibs_pkg::REG_W-1:0];
      res   = mem;
      f     = flags;
      cin   = flags[zibs_pkg::FLAG_C_BIT];
      cout  = 1'b0;
      r.target_addr = base + {{8{disp[7]}}, disp};
      r.mem_write   = 1'b1;
      r.reg_write   = 1'b0;
      case (zibs_pkg::group_type'(op[7:6]))
         zibs_pkg::GROUP_SHIFT: begin
            case (zibs_pkg::shift_type'(sel))
               zibs_pkg::SHIFT_RLC: begin cout = mem[7]; res = {mem[6:0], mem[7]}; end
               zibs_pkg::SHIFT_RRC: begin cout = mem[0]; res = {mem[0], mem[7:1]}; end
               zibs_pkg::SHIFT_RL:  begin cout = mem[7]; res = {mem[6:0], cin}; end
               zibs_pkg::SHIFT_RR:  begin cout = mem[0]; res = {cin, mem[7:1]}; end
               zibs_pkg::SHIFT_SLA: begin cout = mem[7]; res = {mem[6:0], 1'b0}; end
               zibs_pkg::SHIFT_SRA: begin cout = mem[0]; res = {mem[7], mem[7:1]}; end
               zibs_pkg::SHIFT_SLL: begin cout = mem[7]; res = {mem[6:0], 1'b1}; end
               default:             begin cout = mem[0]; res = {1'b0, mem[7:1]}; end
            endcase
            f = '0;
            f[zibs_pkg::FLAG_Y_BIT] = flags[zibs_pkg::FLAG_Y_BIT];
            f[zibs_pkg::FLAG_X_BIT] = flags[zibs_pkg::FLAG_X_BIT];
            f[zibs_pkg::FLAG_S_BIT] = res[7];
            f[zibs_pkg::FLAG_Z_BIT] = (res == '0);
            f[zibs_pkg::FLAG_P_BIT] = ~^res;
            f[zibs_pkg::FLAG_C_BIT] = cout;
            r.reg_write = (rcode != zibs_pkg::REG_MEM);
         end
         zibs_pkg::GROUP_BIT: begin
            r.mem_write = 1'b0;
            f[zibs_pkg::FLAG_Z_BIT] = ~mem[sel];
            f[zibs_pkg::FLAG_H_BIT] = 1'b1;
            f[zibs_pkg::FLAG_N_BIT] = 1'b0;
         end
         zibs_pkg::GROUP_RES: begin
            res[sel] = 1'b0;
            r.reg_write = (rcode != zibs_pkg::REG_MEM);
         end
         default: begin
            res[sel] = 1'b1;
            r.reg_write = (rcode != zibs_pkg::REG_MEM);
         end
      endcase
      r.result_byte = res;
      r.reg_select  = r.reg_write ? rcode : '0;
      r.flags_out   = f;
      return r;
   endfunction

   task automatic report_error(input string msg);
      error_count++;
      $display("[%0t] ERROR: %s", $realtime, msg);
   endtask

   task automatic check_field(input string name, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want)
         report_error($sformatf("result %0d, %s: got %0h, expected %0h",
                                results_checked, name, got, want));
   endtask

   task automatic add_row(input logic [zibs_pkg::OP_W-1:0] op,
                          input logic [zibs_pkg::ADDR_W-1:0] base,
                          input logic [zibs_pkg::DATA_W-1:0] disp,
                          input logic [zibs_pkg::DATA_W-1:0] mem,
                          input logic typed, input zibs_pkg::result_type want);
      directed_rows.push_back({op, base, disp, mem, typed, want});
   endtask

   function automatic instr_row_type random_row();
      instr_row_type row;
      row = '0;
      row.op = 8'($urandom_range(0, 255));
      case ($urandom_range(0, 3))
         0:       row.base_addr = 16'($urandom_range(0, 15));
         1:       row.base_addr = 16'(16'hFFFF - $urandom_range(0, 15));
         default: row.base_addr = 16'($urandom_range(0, 16'hFFFF));
      endcase
      row.displacement = 8'($urandom_range(0, 255));
      case ($urandom_range(0, 7))
         0:       row.mem_value = 8'h00;
         1:       row.mem_value = 8'hFF;
         2:       row.mem_value = 8'h80;
         3:       row.mem_value = 8'h01;
         default: row.mem_value = 8'($urandom_range(0, 255));
      endcase
      return row;
   endfunction

   task automatic send_item(input instr_row_type row);
      int unsigned          gap;
      zibs_pkg::result_type want;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 6);
      end
      burst_left--;
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.op           <= row.op;
      req_bus.base_addr    <= row.base_addr;
      req_bus.displacement <= row.displacement;
      req_bus.mem_value    <= row.mem_value;
      @(posedge clock);
      while (!req_bus.ready) begin
         input_stalls++;
         @(posedge clock);
      end
      want = execute_indexed(row.op, row.base_addr, row.displacement, row.mem_value,
                             flag_model);
      flag_model = want.flags_out;
      if (row.typed) want = row.want;
      pending_results.push_back(want);
      items_accepted++;
      case (zibs_pkg::group_type'(row.op[7:6]))
         zibs_pkg::GROUP_SHIFT: shift_items++;
         zibs_pkg::GROUP_BIT:   bit_items++;
         default:               modify_items++;
      endcase
   endtask

   // stimulus and end of run
   initial begin
      req_bus.valid        <= 1'b0;
      req_bus.op           <= '0;
      req_bus.base_addr    <= '0;
      req_bus.displacement <= '0;
      req_bus.mem_value    <= '0;
      reset                <= 1'b1;

      // first rows: flags straight out of reset, address wrap and sign extension
      add_row(make_op(zibs_pkg::GROUP_SET, 3'd0, zibs_pkg::REG_MEM), 16'hFFFF, 8'h01,
              8'h00, 1'b1, {16'h0000, 1'b1, 8'h01, 1'b0, 3'd0, 8'h00});
      add_row(make_op(zibs_pkg::GROUP_RES, 3'd7, REG_A), 16'h0000, 8'h80, 8'hFF, 1'b1,
              {16'hFF80, 1'b1, 8'h7F, 1'b1, REG_A, 8'h00});
      add_row(make_op(zibs_pkg::GROUP_BIT, 3'd0, zibs_pkg::REG_MEM), 16'h8000, 8'h7F,
              8'h00, 1'b1, {16'h807F, 1'b0, 8'h00, 1'b0, 3'd0, 8'h50});
      add_row(make_op(zibs_pkg::GROUP_BIT, 3'd7, REG_B), 16'h1234, 8'h00, 8'hFF, 1'b1,
              {16'h1234, 1'b0, 8'hFF, 1'b0, 3'd0, 8'h10});
      add_row(make_op(zibs_pkg::GROUP_SHIFT, zibs_pkg::SHIFT_RLC, REG_B), 16'h4000,
              8'h10, 8'h80, 1'b0, '0);
      add_row(make_op(zibs_pkg::GROUP_SHIFT, zibs_pkg::SHIFT_RRC, REG_C), 16'h4000,
              8'hF0, 8'h01, 1'b0, '0);
      add_row(make_op(zibs_pkg::GROUP_SHIFT, zibs_pkg::SHIFT_RL, REG_D), 16'hFFFF,
              8'h7F, 8'h80, 1'b0, '0);
      add_row(make_op(zibs_pkg::GROUP_SHIFT, zibs_pkg::SHIFT_RR, REG_E), 16'h0001,
              8'hFE, 8'h00, 1'b0, '0);
      add_row(make_op(zibs_pkg::GROUP_SHIFT, zibs_pkg::SHIFT_SLA, REG_H), 16'hAAAA,
              8'h55, 8'hFF, 1'b0, '0);
      add_row(make_op(zibs_pkg::GROUP_SHIFT, zibs_pkg::SHIFT_SRA, REG_L), 16'h5555,
              8'hAA, 8'h81, 1'b0, '0);
      add_row(make_op(zibs_pkg::GROUP_SHIFT, zibs_pkg::SHIFT_SLL, zibs_pkg::REG_MEM),
              16'h0080, 8'h80, 8'h00, 1'b0, '0);
      add_row(make_op(zibs_pkg::GROUP_SHIFT, zibs_pkg::SHIFT_SRL, REG_A), 16'hFF7F,
              8'h7F, 8'h01, 1'b0, '0);
      add_row(make_op(zibs_pkg::GROUP_SHIFT, zibs_pkg::SHIFT_RL, zibs_pkg::REG_MEM),
              16'h1000, 8'h01, 8'h7F, 1'b0, '0);
      add_row(make_op(zibs_pkg::GROUP_SHIFT, zibs_pkg::SHIFT_RR, zibs_pkg::REG_MEM),
              16'h1000, 8'hFF, 8'hFE, 1'b0, '0);
      add_row(make_op(zibs_pkg::GROUP_SHIFT, zibs_pkg::SHIFT_SLA, zibs_pkg::REG_MEM),
              16'h2000, 8'h02, 8'h00, 1'b0, '0);
      add_row(make_op(zibs_pkg::GROUP_SHIFT, zibs_pkg::SHIFT_SRA, zibs_pkg::REG_MEM),
              16'h2000, 8'hFD, 8'hFF, 1'b0, '0);
      add_row(make_op(zibs_pkg::GROUP_RES, 3'd0, zibs_pkg::REG_MEM), 16'h7FFF, 8'hFF,
              8'h01, 1'b0, '0);
      add_row(make_op(zibs_pkg::GROUP_SET, 3'd7, REG_H), 16'h8001, 8'h80, 8'h00, 1'b0,
              '0);
      add_row(make_op(zibs_pkg::GROUP_BIT, 3'd3, REG_A), 16'h3000, 8'h03, 8'h08, 1'b0,
              '0);
      add_row(make_op(zibs_pkg::GROUP_BIT, 3'd4, zibs_pkg::REG_MEM), 16'h3000, 8'hFC,
              8'hEF, 1'b0, '0);
      add_row(make_op(zibs_pkg::GROUP_SHIFT, zibs_pkg::SHIFT_RLC, zibs_pkg::REG_MEM),
              16'h0000, 8'h00, 8'h00, 1'b0, '0);
      add_row(make_op(zibs_pkg::GROUP_SHIFT, zibs_pkg::SHIFT_RRC, REG_A), 16'hFFFF,
              8'hFF, 8'hFF, 1'b0, '0);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) send_item(directed_rows[i]);
      for (int n = 0; n < RANDOM_ITEMS; n++) send_item(random_row());
      req_bus.valid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("%0d items (%0d shift/rotate, %0d bit test, %0d res/set), %0d results checked",
               items_accepted, shift_items, bit_items, modify_items, results_checked);
      $display("input stalled %0d cycles, longest output stall %0d cycles",
               input_stalls, longest_stall);
      if (error_count == 0) begin
         $display("tb_z80_indexed_bit_shift_unit OK");
      end else begin
         $display("tb_z80_indexed_bit_shift_unit NOT OK");
      end
      $finish;
   end

   // response side: pattern stalls plus one long hold-off to fill the pipe
   initial begin
      rx_pattern_type pattern;
      int unsigned    phase_left;
      int unsigned    hold_left;
      pattern    = RX_ALWAYS;
      phase_left = 0;
      hold_left  = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!held_off && items_accepted >= 120) begin
            held_off  = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            if (phase_left == 0) begin
               pattern    = rx_pattern_type'($urandom_range(0, 3));
               phase_left = $urandom_range(20, 80);
            end
            phase_left--;
            case (pattern)
               RX_ALWAYS:       rsp_bus.ready <= 1'b1;
               RX_COIN:         rsp_bus.ready <= ($urandom_range(0, 1) != 0);
               RX_ONE_IN_THREE: rsp_bus.ready <= (phase_left % 3 == 0);
               default:         rsp_bus.ready <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   // response checker
   always @(posedge clock) begin
      zibs_pkg::result_type want;
      if (!reset && rsp_bus.valid && !rsp_bus.ready) begin
         stall_run++;
         if (stall_run > longest_stall) longest_stall = stall_run;
      end else begin
         stall_run = 0;
      end
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         results_checked++;
         if (pending_results.size() == 0) begin
            report_error($sformatf("result %0d arrived with no item pending",
                                   results_checked));
         end else begin
            want = pending_results.pop_front();
            check_field("target_addr", 16'(rsp_bus.target_addr), 16'(want.target_addr));
            check_field("mem_write",   16'(rsp_bus.mem_write),   16'(want.mem_write));
            check_field("result_byte", 16'(rsp_bus.result_byte), 16'(want.result_byte));
            check_field("reg_write",   16'(rsp_bus.reg_write),   16'(want.reg_write));
            check_field("reg_select",  16'(rsp_bus.reg_select),  16'(want.reg_select));
            check_field("flags_out",   16'(rsp_bus.flags_out),   16'(want.flags_out));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, pending_results.size());
         $display("tb_z80_indexed_bit_shift_unit NOT OK");
         $finish;
      end
   end

endmodule

// ----- sim.f -----
design/zibs_pkg.sv
design/zibs_if.sv
design/zibs_alu.sv
design/z80_indexed_bit_shift_unit.sv
design/zibs_checker.sv
sim/tb_z80_indexed_bit_shift_unit.sv
